### rtl/core/toeu_pkg.sv
// Package: action codes, payload structs and queue entry type for the execute unit
`timescale 1ns / 1ps
`default_nettype none
package toeu_pkg;

  typedef enum logic [3:0] {
    ACT_ABS_S = 4'd0,
    ACT_ABS   = 4'd1,
    ACT_NEG_S = 4'd2,
    ACT_C_EQ  = 4'd3,
    ACT_C_LE  = 4'd4,
    ACT_C_LT  = 4'd5,
    ACT_MFC1  = 4'd6,
    ACT_MTC1  = 4'd7,
    ACT_CVT   = 4'd8,
    ACT_MULT  = 4'd9,
    ACT_DIV   = 4'd10,
    ACT_NOT   = 4'd11,
    ACT_LUI   = 4'd12,
    ACT_MOVE  = 4'd13,
    ACT_BGEZ  = 4'd14,
    ACT_BEQZ  = 4'd15
  } action_t;

  localparam int LUI_SHIFT = 16;

  localparam logic [1:0] SEL_NONE   = 2'd0;
  localparam logic [1:0] SEL_FIRST  = 2'd1;
  localparam logic [1:0] SEL_SECOND = 2'd2;

  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] first_value;
    logic [31:0] second_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] dest_value;
    logic [1:0]  dest_select;
    logic [31:0] hi_word;
    logic [31:0] lo_word;
    logic        hilo_write;
    logic        cond_flag;
    logic        cond_write;
    logic        branch_taken;
    logic [31:0] branch_target;
    logic        divide_by_zero;
  } out_item_t;

  // Classified item passed from front to back
  typedef struct packed {
    action_t     act;
    logic        is_simple;
    logic        is_mult;
    logic        is_div;
    logic        is_cvt;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] simple_value;
    logic [1:0]  simple_select;
    logic        cond_flag;
    logic        cond_write;
    logic        branch_taken;
  } cls_item_t;

endpackage
`default_nettype wire

### rtl/core/toeu_front.sv
// Front: accept items, classify them and resolve the simple operations
`timescale 1ns / 1ps
`default_nettype none
module toeu_front (
  input  wire  toeu_pkg::in_item_t  in_item,
  output toeu_pkg::cls_item_t       cls_item
);
  import toeu_pkg::*;

  logic [31:0] a, b;
  logic        nan_a, nan_b, sa, sb, both_zero, mag_lt, mag_eq, lt, eq;
  logic [30:0] ma, mb;

  assign a = in_item.first_value;
  assign b = in_item.second_value;
  assign nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  assign nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  assign sa = a[31];
  assign sb = b[31];
  assign ma = a[30:0];
  assign mb = b[30:0];
  assign both_zero = (ma == 31'd0) && (mb == 31'd0);
  assign mag_lt = ma < mb;
  assign mag_eq = ma == mb;
  assign eq = both_zero || (mag_eq && (sa == sb));
  always_comb begin
    if (both_zero) begin
      lt = 1'b0;
    end else if (sa != sb) begin
      lt = sa;
    end else if (sa) begin
      lt = !mag_lt && !mag_eq;
    end else begin
      lt = mag_lt;
    end
  end

  always_comb begin
    cls_item = '0;
    cls_item.act = action_t'(in_item.action);
    cls_item.a = a;
    cls_item.b = b;
    unique case (action_t'(in_item.action))
      ACT_ABS_S: begin
        cls_item.is_simple = 1'b1;
        cls_item.simple_value = {1'b0, b[30:0]};
        cls_item.simple_select = SEL_FIRST;
      end
      ACT_ABS: begin
        cls_item.is_simple = 1'b1;
        cls_item.simple_value = b[31] ? (32'd0 - b) : b;
        cls_item.simple_select = SEL_FIRST;
      end
      ACT_NEG_S: begin
        cls_item.is_simple = 1'b1;
        cls_item.simple_value = {~b[31], b[30:0]};
        cls_item.simple_select = SEL_FIRST;
      end
      ACT_C_EQ, ACT_C_LE, ACT_C_LT: begin
        cls_item.is_simple = 1'b1;
        cls_item.cond_write = 1'b1;
        if (!nan_a && !nan_b) begin
          unique case (action_t'(in_item.action))
            ACT_C_EQ: cls_item.cond_flag = eq;
            ACT_C_LE: cls_item.cond_flag = eq || lt;
            default:  cls_item.cond_flag = lt;
          endcase
        end
      end
      ACT_MFC1, ACT_MOVE: begin
        cls_item.is_simple = 1'b1;
        cls_item.simple_value = b;
        cls_item.simple_select = SEL_FIRST;
      end
      ACT_MTC1: begin
        cls_item.is_simple = 1'b1;
        cls_item.simple_value = a;
        cls_item.simple_select = SEL_SECOND;
      end
      ACT_CVT:  cls_item.is_cvt = 1'b1;
      ACT_MULT: cls_item.is_mult = 1'b1;
      ACT_DIV:  cls_item.is_div = 1'b1;
      ACT_NOT: begin
        cls_item.is_simple = 1'b1;
        cls_item.simple_value = ~b;
        cls_item.simple_select = SEL_FIRST;
      end
      ACT_LUI: begin
        cls_item.is_simple = 1'b1;
        cls_item.simple_value = {b[31-LUI_SHIFT:0], {LUI_SHIFT{1'b0}}};
        cls_item.simple_select = SEL_FIRST;
      end
      ACT_BGEZ: begin
        cls_item.is_simple = 1'b1;
        cls_item.branch_taken = !a[31];
      end
      ACT_BEQZ: begin
        cls_item.is_simple = 1'b1;
        cls_item.branch_taken = (a == 32'd0);
      end
      default: cls_item.is_simple = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/toeu_fifo.sv
// Short queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module toeu_fifo #(
  parameter int DEPTH = 2
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    wr_valid,
  output logic                   wr_ready,
  input  wire  toeu_pkg::cls_item_t wr_item,
  output logic                   rd_valid,
  input  wire                    rd_ready,
  output toeu_pkg::cls_item_t    rd_item
);
  import toeu_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cls_item_t          mem_r [DEPTH];
  logic [AW-1:0]      wp_r, rp_r;
  logic [AW:0]        cnt_r;
  logic               wr_en, rd_en;

  assign wr_ready = cnt_r != (AW+1)'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_item  = mem_r[rp_r];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_item;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH)) else $error("queue overflow");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && !wr_en) |=> cnt_r == $past(cnt_r) - 1'b1) else $error("drain");

endmodule
`default_nettype wire

### rtl/core/toeu_back.sv
// Back: pipelined multiply, divide and conversion, result register
`timescale 1ns / 1ps
`default_nettype none
module toeu_back (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       q_valid,
  output logic                      q_ready,
  input  wire  toeu_pkg::cls_item_t q_item,
  output logic                      out_valid,
  input  wire                       out_ready,
  output toeu_pkg::out_item_t       out_item
);
  import toeu_pkg::*;

  // Pipeline: stage 0 (prep), 32 divide steps, 1 finish stage
  localparam int NDIV = 32;
  localparam int NST  = NDIV + 2;

  typedef struct packed {
    cls_item_t   c;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
    logic [63:0] prod;
    logic [31:0] cvt;
  } pipe_t;

  pipe_t         st_r [NST];
  logic [NST-1:0] v_r;
  logic          adv;
  out_item_t     res_r;
  logic          res_v_r;
  logic          last_v;
  pipe_t         last;
  out_item_t     fin;

  // Hold the whole pipe while the output register is full and not taken
  assign adv = !res_v_r || out_ready;
  assign q_ready = adv;
  assign last = st_r[NST-1];
  assign last_v = v_r[NST-1];

  // Stage 0 combinational prep: signed multiply, cvt normalise, divide magnitudes
  pipe_t         p0;
  logic [31:0]   mag, cm, ma0, mb0;
  logic [4:0]    p;
  logic [31:0]   normd;
  logic          rb, st;
  logic [24:0]   mant;
  logic [7:0]    ex;
  logic signed [63:0] prod_s;

  always_comb begin
    mag = q_item.b[31] ? (32'd0 - q_item.b) : q_item.b;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) p = 5'(i);
    end
    normd = mag << (5'd31 - p);
    mant = {1'b0, normd[31:8]};
    rb = normd[7];
    st = normd[6:0] != 7'd0;
    if (rb && (st || mant[0])) mant = mant + 25'd1;
    ex = 8'd127 + {3'd0, p};
    if (mant[24]) begin
      ex = ex + 8'd1;
      mant = mant >> 1;
    end
    cm = (mag == 32'd0) ? 32'd0 : {q_item.b[31], ex, mant[22:0]};
    ma0 = q_item.a[31] ? (32'd0 - q_item.a) : q_item.a;
    mb0 = q_item.b[31] ? (32'd0 - q_item.b) : q_item.b;
    prod_s = $signed(q_item.a) * $signed(q_item.b);
    p0.c = q_item;
    p0.rem = '0;
    p0.quo = ma0;
    p0.dvs = mb0;
    p0.prod = prod_s;
    p0.cvt = cm;
  end

  // One restoring divide step per stage
  function automatic pipe_t div_step(input pipe_t x);
    pipe_t       y;
    logic [32:0] t;
    y = x;
    t = {x.rem, x.quo[31]} - {1'b0, x.dvs};
    if (!t[32]) begin
      y.rem = t[31:0];
      y.quo = {x.quo[30:0], 1'b1};
    end else begin
      y.rem = {x.rem[30:0], x.quo[31]};
      y.quo = {x.quo[30:0], 1'b0};
    end
    return y;
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= p0;
      for (int s = 1; s <= NDIV; s++) begin
        st_r[s] <= st_r[s-1].c.is_div ? div_step(st_r[s-1]) : st_r[s-1];
      end
      st_r[NST-1] <= st_r[NST-2];
      if (last_v) res_r <= fin;
    end
    if (!rst_n) begin
      v_r <= '0;
      res_v_r <= 1'b0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], q_valid};
      res_v_r <= last_v;
    end
  end

  always_comb begin
    fin = '0;
    if (last.c.is_simple) begin
      fin.dest_value = last.c.simple_value;
      fin.dest_select = last.c.simple_select;
      fin.cond_flag = last.c.cond_flag;
      fin.cond_write = last.c.cond_write;
      fin.branch_taken = last.c.branch_taken;
      fin.branch_target = last.c.branch_taken ? last.c.b : 32'd0;
    end else if (last.c.is_cvt) begin
      fin.dest_value = last.cvt;
      fin.dest_select = SEL_FIRST;
    end else if (last.c.is_mult) begin
      fin.hi_word = last.prod[63:32];
      fin.lo_word = last.prod[31:0];
      fin.hilo_write = 1'b1;
    end else if (last.c.b == 32'd0) begin
      fin.divide_by_zero = 1'b1;
    end else begin
      fin.lo_word = (last.c.a[31] ^ last.c.b[31]) ? (32'd0 - last.quo) : last.quo;
      fin.hi_word = last.c.a[31] ? (32'd0 - last.rem) : last.rem;
      fin.hilo_write = 1'b1;
    end
  end

  assign out_valid = res_v_r;
  assign out_item = res_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(v_r)) else $error("pipe moved in stall");
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.divide_by_zero && out_item.hilo_write))
    else $error("dz with hilo write");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last_v) |=> res_v_r) else $error("result lost");

endmodule
`default_nettype wire

### rtl/core/two_operand_execute_unit_top.sv
// Top level of the two-operand execute unit
`timescale 1ns / 1ps
`default_nettype none
// Executes one integer or single-float instruction per item and accepts a new
// item every cycle while the queue has room. The front classifies each item
// and resolves the simple operations; a two-entry queue feeds a 34-stage back
// pipeline (multiply and conversion in its first stage, one restoring divide
// bit per stage), followed by an output register. The pipeline depth is set
// by the 32-step divide.
module two_operand_execute_unit_top (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire  toeu_pkg::in_item_t  in_item,
  output logic                      out_valid,
  input  wire                       out_ready,
  output toeu_pkg::out_item_t       out_item
);
  import toeu_pkg::*;

  cls_item_t f_item, q_item;
  logic      q_valid, q_ready;

  toeu_front u_front (.in_item(in_item), .cls_item(f_item));

  toeu_fifo #(.DEPTH(2)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_item(f_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  toeu_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

endmodule
`default_nettype wire
